// ===== hw/rtl/rfdmf_pkg.sv =====
// Package for the region frame-difference motion flags block.
// Holds widths, region bounds, register defaults, payload types and the grey helper.
// Used by the top level and the testbench.
package rfdmf_pkg;

    localparam int BAND_ROWS_DEF      = 120;
    localparam int STORED_COLUMNS_DEF = 660;

    localparam int PIX_W      = 8;
    localparam int COORD_W    = 11;
    localparam int COUNT_W    = 16;
    localparam int TIME_W     = 48;
    localparam int HOLD_W     = 24;
    localparam int OFFSET_W   = 10;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int NUM_REGIONS = 3;

    localparam int BAND_TOP    = 450;
    localparam int LEFT_HI     = 300;
    localparam int CENTER_LO   = 470;
    localparam int CENTER_HI   = 580;
    localparam int RIGHT_LO    = 700;
    localparam int RIGHT_HI    = 950;
    localparam int CENTER_BASE = 300;
    localparam int RIGHT_BASE  = 410;

    localparam int GREY_ACC_W = 22;
    localparam int GREY_SHIFT = 14;
    localparam int W_RED      = 4899;
    localparam int W_GREEN    = 9617;
    localparam int W_BLUE     = 1868;
    localparam int GREY_ROUND = 8192;

    localparam logic [PIX_W-1:0]   PIX_THR_RST    = 8'd15;
    localparam logic [COUNT_W-1:0] LEFT_THR_RST   = 16'd600;
    localparam logic [COUNT_W-1:0] CENTER_THR_RST = 16'd250;
    localparam logic [COUNT_W-1:0] RIGHT_THR_RST  = 16'd500;
    localparam logic [HOLD_W-1:0]  HOLD_RST       = 24'd1000000;
    localparam logic [COUNT_W-1:0] COUNT_MAX      = 16'hFFFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENABLE,
        CFG_PIX_THR,
        CFG_LEFT_THR,
        CFG_CENTER_THR,
        CFG_RIGHT_THR,
        CFG_HOLD
    } t_cfg_idx;

    typedef enum logic [1:0] {
        RGN_LEFT,
        RGN_CENTER,
        RGN_RIGHT,
        RGN_NONE
    } t_region;

    typedef struct packed {
        t_region               region;
        logic [OFFSET_W-1:0]   offset;
    } t_loc;

    typedef struct packed {
        logic [PIX_W-1:0]   red;
        logic [PIX_W-1:0]   green;
        logic [PIX_W-1:0]   blue;
        logic [COORD_W-1:0] pixel_column;
        logic [COORD_W-1:0] pixel_row;
        logic               frame_last;
        logic [TIME_W-1:0]  frame_time_us;
    } t_pix;

    typedef struct packed {
        logic               traffic_left;
        logic               traffic_center;
        logic               traffic_right;
        logic [COUNT_W-1:0] left_changed;
        logic [COUNT_W-1:0] center_changed;
        logic [COUNT_W-1:0] right_changed;
        logic [TIME_W-1:0]  result_time_us;
    } t_res;

    typedef struct packed {
        t_cfg_idx              reg_index;
        logic [CFG_DATA_W-1:0] reg_data;
    } t_cfg_req;

    function automatic logic [PIX_W-1:0] grey_of(input logic [PIX_W-1:0] r,
                                                 input logic [PIX_W-1:0] g,
                                                 input logic [PIX_W-1:0] b);
        logic [GREY_ACC_W-1:0] acc;
        acc = GREY_ACC_W'(W_RED) * GREY_ACC_W'(r)
            + GREY_ACC_W'(W_GREEN) * GREY_ACC_W'(g)
            + GREY_ACC_W'(W_BLUE) * GREY_ACC_W'(b)
            + GREY_ACC_W'(GREY_ROUND);
        return acc[GREY_ACC_W-1:GREY_SHIFT];
    endfunction

    function automatic t_loc locate(input logic [COORD_W-1:0] col);
        t_loc loc;
        loc.region = RGN_NONE;
        loc.offset = '0;
        if (col < COORD_W'(LEFT_HI)) begin
            loc.region = RGN_LEFT;
            loc.offset = OFFSET_W'(col);
        end else if (col >= COORD_W'(CENTER_LO) && col < COORD_W'(CENTER_HI)) begin
            loc.region = RGN_CENTER;
            loc.offset = OFFSET_W'(col - COORD_W'(CENTER_LO) + COORD_W'(CENTER_BASE));
        end else if (col >= COORD_W'(RIGHT_LO) && col < COORD_W'(RIGHT_HI)) begin
            loc.region = RGN_RIGHT;
            loc.offset = OFFSET_W'(col - COORD_W'(RIGHT_LO) + COORD_W'(RIGHT_BASE));
        end
        return loc;
    endfunction

endpackage

// ===== hw/rtl/rfdmf_stream_if.sv =====
// Valid/ready stream interface used for pixels, results and register writes.
// The payload type is a parameter; types come from rfdmf_pkg.
interface rfdmf_stream_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/roi_frame_difference_motion_flags.sv =====
// Top level of the region frame-difference motion flags block; uses rfdmf_pkg,
// rfdmf_stream_if and rfdmf_ram for the previous-frame grey store.
// A frame's result is registered into o_res after its last pixel has passed stages A, B and C.
// Throughput: one pixel per cycle; input stalls only while a frame-end result waits
// behind an untaken result in the output register.
// Reset (synchronous, active low) clears flags, counts and pipeline valids and loads
// register defaults; the grey store is not cleared and has no clearing pass.
module roi_frame_difference_motion_flags #(
    parameter int BAND_ROWS      = rfdmf_pkg::BAND_ROWS_DEF,
    parameter int STORED_COLUMNS = rfdmf_pkg::STORED_COLUMNS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    rfdmf_stream_if.sink    i_pix,
    rfdmf_stream_if.source  o_res,
    rfdmf_stream_if.sink    i_cfg
);
    import rfdmf_pkg::*;

    localparam int DEPTH = BAND_ROWS * STORED_COLUMNS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int ROW_W = (BAND_ROWS > 1) ? $clog2(BAND_ROWS) : 1;
    localparam int SC_W  = COORD_W + 1;

    // Configuration registers.
    logic               r_enable;
    logic [PIX_W-1:0]   r_pix_thr;
    logic [COUNT_W-1:0] r_cnt_thr [NUM_REGIONS];
    logic [HOLD_W-1:0]  r_hold;

    // Pipeline stages.
    logic               r_a_valid;
    t_pix               r_a_pix;

    logic               r_b_valid;
    logic               r_b_active;
    logic               r_b_in_store;
    t_region            r_b_region;
    logic [AW-1:0]      r_b_addr;
    logic [PIX_W-1:0]   r_b_grey;
    logic               r_b_last;
    logic [TIME_W-1:0]  r_b_time;
    logic               r_b_fwd;
    logic [PIX_W-1:0]   r_b_fwd_grey;

    logic               r_c_valid;
    logic               r_c_active;
    logic               r_c_changed;
    t_region            r_c_region;
    logic               r_c_last;
    logic [TIME_W-1:0]  r_c_time;

    // Frame state.
    logic               r_first_done;
    logic [COUNT_W-1:0] r_count [NUM_REGIONS];
    logic               r_flag  [NUM_REGIONS];
    logic               r_armed [NUM_REGIONS];
    logic [TIME_W-1:0]  r_stamp [NUM_REGIONS];

    logic [COUNT_W-1:0] n_count [NUM_REGIONS];
    logic               n_flag  [NUM_REGIONS];
    logic               n_armed [NUM_REGIONS];
    logic [TIME_W-1:0]  n_stamp [NUM_REGIONS];
    logic [COUNT_W-1:0] cnt_new [NUM_REGIONS];

    logic               r_out_valid;
    t_res               r_out;

    // Stage A combinational signals.
    t_loc               a_loc;
    logic [COORD_W-1:0] a_row_rel;
    logic               a_in_band;
    logic               a_active;
    logic               a_in_store;
    logic [AW-1:0]      a_addr;
    logic [PIX_W-1:0]   a_grey;
    logic               a_fwd_hit;

    // Stage B combinational signals.
    logic [PIX_W-1:0]   ram_rdata;
    logic [PIX_W-1:0]   b_old;
    logic [PIX_W-1:0]   b_diff;
    logic               b_changed;

    // Stage C and control.
    logic               frame_end;
    logic               emit;
    logic               stall;
    logic               adv;
    logic               accept;

    assign a_loc      = locate(r_a_pix.pixel_column);
    assign a_row_rel  = r_a_pix.pixel_row - COORD_W'(BAND_TOP);
    assign a_in_band  = (r_a_pix.pixel_row >= COORD_W'(BAND_TOP))
                     && (SC_W'(a_row_rel) < SC_W'(BAND_ROWS));
    assign a_active   = r_a_valid && r_enable && a_in_band && (a_loc.region != RGN_NONE);
    assign a_in_store = a_active && (SC_W'(a_loc.offset) < SC_W'(STORED_COLUMNS));
    assign a_addr     = AW'(a_row_rel[ROW_W-1:0]) * AW'(STORED_COLUMNS) + AW'(a_loc.offset);
    assign a_grey     = grey_of(r_a_pix.red, r_a_pix.green, r_a_pix.blue);
    assign a_fwd_hit  = r_b_valid && r_b_in_store && (r_b_addr == a_addr);

    rfdmf_ram #(
        .WIDTH (PIX_W),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (adv && r_b_valid && r_b_in_store),
        .i_waddr (r_b_addr),
        .i_wdata (r_b_grey),
        .i_re    (adv),
        .i_raddr (a_addr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        if (!r_b_in_store) begin
            b_old = '0;
        end else if (r_b_fwd) begin
            b_old = r_b_fwd_grey;
        end else begin
            b_old = ram_rdata;
        end
        b_diff    = (r_b_grey > b_old) ? (r_b_grey - b_old) : (b_old - r_b_grey);
        b_changed = b_diff > r_pix_thr;
    end

    assign frame_end = r_c_valid && r_c_last;
    assign emit      = frame_end && r_enable;
    assign stall     = emit && r_out_valid && !o_res.ready;
    assign adv       = !stall;
    assign accept    = i_pix.valid && adv;

    assign i_pix.ready = adv;
    assign i_cfg.ready = 1'b1;
    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out;

    always_comb begin
        for (int i = 0; i < NUM_REGIONS; i++) begin
            if (r_c_valid && r_c_active && r_c_changed && r_first_done
                    && (r_c_region == t_region'(i)) && (r_count[i] != COUNT_MAX)) begin
                cnt_new[i] = r_count[i] + COUNT_W'(1);
            end else begin
                cnt_new[i] = r_count[i];
            end
            n_count[i] = cnt_new[i];
            n_flag[i]  = r_flag[i];
            n_armed[i] = r_armed[i];
            n_stamp[i] = r_stamp[i];
            if (frame_end) begin
                n_count[i] = '0;
                if (!r_enable) begin
                    n_flag[i]  = 1'b0;
                    n_armed[i] = 1'b0;
                end else if (cnt_new[i] > r_cnt_thr[i]) begin
                    n_flag[i]  = 1'b1;
                    n_armed[i] = 1'b0;
                end else if (!r_armed[i]) begin
                    n_stamp[i] = r_c_time;
                    n_armed[i] = 1'b1;
                end else if ((r_c_time > r_stamp[i])
                        && ((r_c_time - r_stamp[i]) > TIME_W'(r_hold))) begin
                    n_flag[i] = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable     <= 1'b0;
            r_pix_thr    <= PIX_THR_RST;
            r_cnt_thr[0] <= LEFT_THR_RST;
            r_cnt_thr[1] <= CENTER_THR_RST;
            r_cnt_thr[2] <= RIGHT_THR_RST;
            r_hold       <= HOLD_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.data.reg_index)
                CFG_ENABLE:     r_enable     <= i_cfg.data.reg_data[0];
                CFG_PIX_THR:    r_pix_thr    <= i_cfg.data.reg_data[PIX_W-1:0];
                CFG_LEFT_THR:   r_cnt_thr[0] <= i_cfg.data.reg_data[COUNT_W-1:0];
                CFG_CENTER_THR: r_cnt_thr[1] <= i_cfg.data.reg_data[COUNT_W-1:0];
                CFG_RIGHT_THR:  r_cnt_thr[2] <= i_cfg.data.reg_data[COUNT_W-1:0];
                CFG_HOLD:       r_hold       <= i_cfg.data.reg_data[HOLD_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else if (adv) begin
            r_a_valid <= accept;
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            if (accept) begin
                r_a_pix <= i_pix.data;
            end
            r_b_active   <= a_active;
            r_b_in_store <= a_in_store;
            r_b_region   <= a_loc.region;
            r_b_addr     <= a_addr;
            r_b_grey     <= a_grey;
            r_b_last     <= r_a_pix.frame_last;
            r_b_time     <= r_a_pix.frame_time_us;
            r_b_fwd      <= a_fwd_hit;
            r_b_fwd_grey <= r_b_grey;
            r_c_active   <= r_b_active;
            r_c_changed  <= b_changed;
            r_c_region   <= r_b_region;
            r_c_last     <= r_b_last;
            r_c_time     <= r_b_time;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_done <= 1'b0;
            for (int i = 0; i < NUM_REGIONS; i++) begin
                r_count[i] <= '0;
                r_flag[i]  <= 1'b0;
                r_armed[i] <= 1'b0;
            end
        end else if (adv && r_c_valid) begin
            if (emit) begin
                r_first_done <= 1'b1;
            end
            for (int i = 0; i < NUM_REGIONS; i++) begin
                r_count[i] <= n_count[i];
                r_flag[i]  <= n_flag[i];
                r_armed[i] <= n_armed[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && r_c_valid) begin
            for (int i = 0; i < NUM_REGIONS; i++) begin
                r_stamp[i] <= n_stamp[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit && adv) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit && adv) begin
            r_out.traffic_left   <= n_flag[0];
            r_out.traffic_center <= n_flag[1];
            r_out.traffic_right  <= n_flag[2];
            r_out.left_changed   <= cnt_new[0];
            r_out.center_changed <= cnt_new[1];
            r_out.right_changed  <= cnt_new[2];
            r_out.result_time_us <= r_c_time;
        end
    end

endmodule

// ===== hw/rtl/rfdmf_ram.sv =====
// Generic simple dual-port RAM with one write port and one registered read port.
// A read at the address being written returns the old contents. No dependencies.
module rfdmf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== tb/sv/roi_frame_difference_motion_flags_test.sv =====
// Self-checking testbench for roi_frame_difference_motion_flags.
// Drives pixel frames and register writes through rfdmf_stream_if and checks every flag
// report against an in-bench model of the grey store, region counts and hold timers.
module roi_frame_difference_motion_flags_test;
    timeunit 1ns;
    timeprecision 1ps;

    import rfdmf_pkg::*;

    localparam int BAND_H       = 120;
    localparam int STORE_W      = 660;
    localparam int STORE_CELLS  = BAND_H * STORE_W;
    localparam int ROI_TOP      = 450;
    localparam int RESET_CYCLES = 9;
    localparam int DRAIN_CYCLES = 12;
    localparam int LONG_HOLD    = 400;
    localparam int END_WAIT     = 5000;
    localparam int RANDOM_ITEMS = 1550;

    class motion_scoreboard;
        bit [7:0]  grey_store [STORE_CELLS];
        bit        written [STORE_CELLS];
        int        spot_rows [$];
        int        spot_cols [$];
        bit        first_done;
        bit [15:0] counts [3];
        bit        flags [3];
        bit        armed [3];
        bit [47:0] stamps [3];
        bit        en;
        bit [7:0]  pix_thr = 8'd15;
        bit [15:0] cnt_thr [3] = '{16'd600, 16'd250, 16'd500};
        bit [23:0] hold = 24'd1000000;
        t_res      due_reports [$];
        int        faults;
        int        mismatches;

        function t_region region_of(int col, output int offset);
            offset = 0;
            if (col < 300) begin
                offset = col;
                return RGN_LEFT;
            end
            if (col >= 470 && col < 580) begin
                offset = 300 + col - 470;
                return RGN_CENTER;
            end
            if (col >= 700 && col < 950) begin
                offset = 410 + col - 700;
                return RGN_RIGHT;
            end
            return RGN_NONE;
        endfunction

        function int store_addr(int row, int col);
            int offset;
            t_region rg;
            rg = region_of(col, offset);
            if (rg == RGN_NONE || offset >= STORE_W) return -1;
            return (row - ROI_TOP) * STORE_W + offset;
        endfunction

        function void note_config(t_cfg_idx idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_ENABLE:     en = val[0];
                CFG_PIX_THR:    pix_thr = val[7:0];
                CFG_LEFT_THR:   cnt_thr[0] = val[15:0];
                CFG_CENTER_THR: cnt_thr[1] = val[15:0];
                CFG_RIGHT_THR:  cnt_thr[2] = val[15:0];
                CFG_HOLD:       hold = val[23:0];
                default: ;
            endcase
        endfunction

        function void note_pixel(t_pix p);
            t_region rg;
            int offset, addr, grey, old, diff, r;
            bit in_store;
            t_res rep;
            if (en && p.pixel_row >= ROI_TOP && p.pixel_row < ROI_TOP + BAND_H) begin
                rg = region_of(p.pixel_column, offset);
                if (rg != RGN_NONE) begin
                    grey = (4899 * p.red + 9617 * p.green + 1868 * p.blue + 8192) >> 14;
                    addr = (p.pixel_row - ROI_TOP) * STORE_W + offset;
                    in_store = offset < STORE_W && addr < STORE_CELLS;
                    old = in_store ? grey_store[addr] : 0;
                    diff = grey > old ? grey - old : old - grey;
                    if (first_done && diff > pix_thr && counts[int'(rg)] != 16'hFFFF)
                        counts[int'(rg)]++;
                    if (in_store) begin
                        if (!written[addr]) begin
                            written[addr] = 1'b1;
                            spot_rows.push_back(p.pixel_row);
                            spot_cols.push_back(p.pixel_column);
                        end
                        grey_store[addr] = grey[7:0];
                    end
                end
            end
            if (!p.frame_last) return;
            if (!en) begin
                for (r = 0; r < 3; r++) begin
                    flags[r] = 1'b0;
                    armed[r] = 1'b0;
                    counts[r] = '0;
                end
                return;
            end
            for (r = 0; r < 3; r++) begin
                if (counts[r] > cnt_thr[r]) begin
                    flags[r] = 1'b1;
                    armed[r] = 1'b0;
                end else if (!armed[r]) begin
                    stamps[r] = p.frame_time_us;
                    armed[r] = 1'b1;
                end else if (p.frame_time_us > stamps[r]
                             && p.frame_time_us - stamps[r] > 48'(hold)) begin
                    flags[r] = 1'b0;
                end
            end
            rep.traffic_left   = flags[0];
            rep.traffic_center = flags[1];
            rep.traffic_right  = flags[2];
            rep.left_changed   = counts[0];
            rep.center_changed = counts[1];
            rep.right_changed  = counts[2];
            rep.result_time_us = p.frame_time_us;
            due_reports.push_back(rep);
            for (r = 0; r < 3; r++) counts[r] = '0;
            first_done = 1'b1;
        endfunction

        function void compare_field(string name, logic [47:0] want, logic [47:0] got);
            if (want !== got) begin
                faults++;
                mismatches++;
                if (mismatches <= 10)
                    $display("Mismatch in %s: expected %0h, got %0h", name, want, got);
            end
        endfunction

        function void check_report(t_res got);
            t_res want;
            if (due_reports.size() == 0) begin
                faults++;
                mismatches++;
                if (mismatches <= 10) $display("Flag report with none pending: %p", got);
                return;
            end
            want = due_reports.pop_front();
            compare_field("traffic_left", want.traffic_left, got.traffic_left);
            compare_field("traffic_center", want.traffic_center, got.traffic_center);
            compare_field("traffic_right", want.traffic_right, got.traffic_right);
            compare_field("left_changed", want.left_changed, got.left_changed);
            compare_field("center_changed", want.center_changed, got.center_changed);
            compare_field("right_changed", want.right_changed, got.right_changed);
            compare_field("result_time_us", want.result_time_us, got.result_time_us);
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    bit          quiet_gaps;
    bit          hold_request;
    logic [47:0] clock_us;
    int          work_items;

    motion_scoreboard board = new();

    rfdmf_stream_if #(.T(t_pix))     pix_if ();
    rfdmf_stream_if #(.T(t_res))     res_if ();
    rfdmf_stream_if #(.T(t_cfg_req)) cfg_if ();

    roi_frame_difference_motion_flags #(
        .BAND_ROWS      (BAND_H),
        .STORED_COLUMNS (STORE_W)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_if),
        .o_res   (res_if),
        .i_cfg   (cfg_if)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #4_000_000;
        $display("Some tests failed");
        $finish;
    end

    function automatic int pick_gap();
        int pick;
        if (quiet_gaps) return 0;
        pick = $urandom_range(99);
        if (pick < 55) return 0;
        if (pick < 85) return $urandom_range(1, 3);
        if (pick < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    initial begin
        int stall;
        stall = 0;
        res_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                stall = LONG_HOLD;
                hold_request = 1'b0;
            end
            if (stall > 0) begin
                res_if.ready <= 1'b0;
                stall--;
            end else begin
                res_if.ready <= 1'b1;
                stall = pick_gap();
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready) board.check_report(res_if.data);
    end

    function automatic t_pix pixel_at(int row, int col, logic [7:0] r, logic [7:0] g,
                                      logic [7:0] b, bit last);
        t_pix p;
        p.red = r;
        p.green = g;
        p.blue = b;
        p.pixel_column = 11'(col);
        p.pixel_row = 11'(row);
        p.frame_last = last;
        p.frame_time_us = clock_us;
        return p;
    endfunction

    function automatic t_pix next_pixel(bit noisy, bit last);
        t_pix p;
        int pick, spot, old, v, row, col;
        p = pixel_at(0, 0, 8'($urandom), 8'($urandom), 8'($urandom), last);
        if (noisy && !last) p.frame_time_us = 48'({$urandom, $urandom});
        pick = $urandom_range(99);
        if ((!board.en && !noisy) || (board.en && !board.first_done && pick < 85)) begin
            row = ROI_TOP + $urandom_range(BAND_H - 1);
            case ($urandom_range(2))
                0: col = $urandom_range(299);
                1: col = 470 + $urandom_range(109);
                default: col = 700 + $urandom_range(249);
            endcase
        end else if (!board.en) begin
            row = $urandom_range(2047);
            col = $urandom_range(2047);
        end else if (board.first_done && board.spot_rows.size() > 0
                     && pick < (noisy ? 30 : 85)) begin
            spot = $urandom_range(board.spot_rows.size() - 1);
            row = board.spot_rows[spot];
            col = board.spot_cols[spot];
            old = board.grey_store[board.store_addr(row, col)];
            v = -1;
            case ($urandom_range(5))
                1: v = old + board.pix_thr + 1;
                2: v = old + board.pix_thr;
                3: v = old - board.pix_thr - 1;
                4: v = old - board.pix_thr;
                5: v = $urandom_range(1) * 255;
                default: ;
            endcase
            if (v != -1) begin
                if (v > 255) v = 255;
                if (v < 0) v = 0;
                p.red = 8'(v);
                p.green = 8'(v);
                p.blue = 8'(v);
            end
        end else if ($urandom_range(1)) begin
            row = $urandom_range(1) ? $urandom_range(ROI_TOP - 1)
                                    : $urandom_range(2047, ROI_TOP + BAND_H);
            col = $urandom_range(2047);
        end else begin
            row = ROI_TOP + $urandom_range(BAND_H - 1);
            case ($urandom_range(2))
                0: col = $urandom_range(469, 300);
                1: col = $urandom_range(699, 580);
                default: col = $urandom_range(2047, 950);
            endcase
        end
        p.pixel_row = 11'(row);
        p.pixel_column = 11'(col);
        return p;
    endfunction

    function automatic void next_frame_time();
        logic [63:0] t;
        int pick;
        t = 64'(clock_us);
        pick = $urandom_range(99);
        if (pick < 30)      t = t + board.hold + $urandom_range(1);
        else if (pick < 60) t = t + $urandom_range(board.hold / 2);
        else if (pick < 75) t = t + $urandom_range(3);
        else if (pick < 85) t = t - $urandom_range(board.hold + 10);
        else if (pick < 92) t = 64'hFFFF_FFFF_FFFF - $urandom_range(2);
        else                t = $urandom_range(5);
        clock_us = t[47:0];
    endfunction

    task automatic send_pixel(input t_pix p);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            pix_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        pix_if.valid <= 1'b1;
        pix_if.data <= p;
        @(posedge i_clk);
        while (!pix_if.ready) @(posedge i_clk);
        work_items++;
        board.note_pixel(p);
        @(negedge i_clk);
    endtask

    task automatic run_frame(input int len, input bit noisy);
        int i;
        next_frame_time();
        for (i = 0; i < len; i++) send_pixel(next_pixel(noisy, i == len - 1));
    endtask

    task automatic settle();
        pix_if.valid <= 1'b0;
        while (board.due_reports.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] val);
        t_cfg_req req;
        req.reg_index = idx;
        req.reg_data = val;
        cfg_if.valid <= 1'b1;
        cfg_if.data <= req;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        board.note_config(idx, val);
        @(negedge i_clk);
    endtask

    task automatic program_regs(input bit en, input logic [7:0] pthr, input logic [15:0] lthr,
                                input logic [15:0] cthr, input logic [15:0] rthr,
                                input logic [23:0] hold);
        logic [31:0] junk;
        junk = $urandom;
        write_reg(CFG_ENABLE, {junk[22:0], en});
        write_reg(CFG_PIX_THR, {junk[15:0], pthr});
        write_reg(CFG_LEFT_THR, {junk[7:0], lthr});
        write_reg(CFG_CENTER_THR, {junk[15:8], cthr});
        write_reg(CFG_RIGHT_THR, {junk[23:16], rthr});
        write_reg(CFG_HOLD, hold);
        cfg_if.valid <= 1'b0;
    endtask

    function automatic logic [15:0] random_count_thr();
        case ($urandom_range(9))
            0: return 16'd0;
            1: return 16'hFFFF;
            2: return 16'($urandom);
            default: return 16'($urandom_range(12));
        endcase
    endfunction

    task automatic program_random();
        bit en;
        logic [7:0] pthr;
        logic [23:0] hold;
        en = $urandom_range(99) < 85;
        case ($urandom_range(5))
            0: pthr = 8'd0;
            1: pthr = 8'd255;
            2, 3: pthr = 8'($urandom_range(5, 40));
            default: pthr = 8'($urandom);
        endcase
        case ($urandom_range(4))
            0: hold = 24'd0;
            1: hold = 24'hFFFFFF;
            2: hold = 24'($urandom_range(1000));
            default: hold = 24'($urandom);
        endcase
        program_regs(en, pthr, random_count_thr(), random_count_thr(), random_count_thr(),
                     hold);
    endtask

    initial begin
        int i, frames, guard;
        bit pressure_done;
        pix_if.valid = 1'b0;
        pix_if.data = '0;
        cfg_if.valid = 1'b0;
        cfg_if.data = '0;
        i_rst_n = 1'b0;
        quiet_gaps = 1'b0;
        hold_request = 1'b0;
        clock_us = '0;
        work_items = 0;
        pressure_done = 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Frames arriving before the block is enabled must leave no report.
        send_pixel(pixel_at(ROI_TOP, 0, 8'd255, 8'd255, 8'd255, 1'b0));
        clock_us = 48'hFFFF_FFFF_FFFF;
        send_pixel(pixel_at(ROI_TOP + BAND_H - 1, 949, 8'd0, 8'd0, 8'd0, 1'b1));
        settle();
        program_regs(1'b1, 8'd20, 16'd0, 16'd0, 16'd0, 24'd0);

        // The first enabled frame fills the store and counts nothing.
        clock_us = '0;
        send_pixel(pixel_at(450, 0, 8'd0, 8'd0, 8'd0, 1'b0));
        send_pixel(pixel_at(450, 299, 8'd255, 8'd255, 8'd255, 1'b0));
        send_pixel(pixel_at(450, 470, 8'd255, 8'd0, 8'd0, 1'b0));
        send_pixel(pixel_at(569, 579, 8'd0, 8'd255, 8'd0, 1'b0));
        send_pixel(pixel_at(569, 700, 8'd0, 8'd0, 8'd255, 1'b0));
        send_pixel(pixel_at(569, 949, 8'd100, 8'd100, 8'd100, 1'b0));
        send_pixel(pixel_at(500, 150, 8'd50, 8'd50, 8'd50, 1'b0));
        send_pixel(pixel_at(449, 0, 8'($urandom), 8'($urandom), 8'($urandom), 1'b0));
        send_pixel(pixel_at(570, 0, 8'($urandom), 8'($urandom), 8'($urandom), 1'b0));
        send_pixel(pixel_at(450, 300, 8'($urandom), 8'($urandom), 8'($urandom), 1'b0));
        send_pixel(pixel_at(450, 469, 8'($urandom), 8'($urandom), 8'($urandom), 1'b0));
        send_pixel(pixel_at(450, 580, 8'($urandom), 8'($urandom), 8'($urandom), 1'b0));
        send_pixel(pixel_at(450, 699, 8'($urandom), 8'($urandom), 8'($urandom), 1'b0));
        send_pixel(pixel_at(450, 950, 8'($urandom), 8'($urandom), 8'($urandom), 1'b0));
        for (i = 0; i < 40; i++) send_pixel(next_pixel(1'b0, 1'b0));
        send_pixel(pixel_at(2047, 2047, 8'($urandom), 8'($urandom), 8'($urandom), 1'b1));

        // Full-swing changes, a repeated location and both sides of the pixel threshold.
        clock_us = 48'hFFFF_FFFF_FFFF;
        send_pixel(pixel_at(450, 0, 8'd255, 8'd255, 8'd255, 1'b0));
        send_pixel(pixel_at(450, 0, 8'd0, 8'd0, 8'd0, 1'b0));
        send_pixel(pixel_at(450, 299, 8'd0, 8'd0, 8'd0, 1'b0));
        send_pixel(pixel_at(450, 470, 8'd0, 8'd0, 8'd255, 1'b0));
        send_pixel(pixel_at(569, 579, 8'd255, 8'd0, 8'd255, 1'b0));
        send_pixel(pixel_at(569, 700, 8'd255, 8'd255, 8'd0, 1'b0));
        send_pixel(pixel_at(569, 949, 8'd120, 8'd120, 8'd120, 1'b0));
        send_pixel(pixel_at(500, 150, 8'd71, 8'd71, 8'd71, 1'b1));

        while (work_items < RANDOM_ITEMS) begin
            settle();
            if (!pressure_done && work_items > RANDOM_ITEMS / 2) begin
                program_regs(1'b1, 8'd10, 16'd2, 16'd2, 16'd2, 24'd50);
                quiet_gaps = 1'b1;
                hold_request = 1'b1;
                for (frames = 0; frames < 24; frames++) run_frame($urandom_range(1, 3), 1'b0);
                pressure_done = 1'b1;
            end else begin
                program_random();
                quiet_gaps = $urandom_range(3) == 0;
                for (frames = $urandom_range(2, 6); frames > 0; frames--)
                    run_frame($urandom_range(19) == 0 ? $urandom_range(60, 150)
                                                      : $urandom_range(1, 30),
                              $urandom_range(9) < 2);
            end
            quiet_gaps = 1'b0;
        end

        pix_if.valid <= 1'b0;
        guard = 0;
        while (board.due_reports.size() != 0 && guard < END_WAIT) begin
            @(negedge i_clk);
            guard++;
        end
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (board.due_reports.size() != 0) begin
            board.faults++;
            $display("%0d flag reports never arrived", board.due_reports.size());
        end
        if (board.faults == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
